### hw/rtl/mtcd_pkg.sv
// Shared types and constants of the missing-tooth crank decoder.
// Used by the decoder top level and by its port checker.
`default_nettype none

package mtcd_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOOTH_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINE_OFFSET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_MIN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIMEOUT = 2'd3;
  localparam int unsigned CFG_DATA_W = 24;

  // operation codes of the input word
  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // field widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned TOOTH_W  = 6;   // tooth count and offset, up to 63
  localparam int unsigned POS_W    = 7;
  localparam int unsigned FINE_W   = 17;
  localparam int unsigned NOISE_W  = 16;
  localparam int unsigned TMO_W    = 24;
  localparam int unsigned RPM_W    = 16;
  localparam int unsigned ANGLE_W  = 16;

  // period history
  localparam int unsigned HIST_DEPTH = 4;
  localparam int unsigned HIST_PTR_W = 2;
  localparam int unsigned SUM_W      = TIME_W + HIST_PTR_W;

  // arithmetic widths
  localparam int unsigned DEN_W  = TIME_W + TOOTH_W;   // teeth * period
  localparam int unsigned NUM_W  = 54;                 // 36000 * teeth * period
  localparam int unsigned SHF_W  = 26;                 // bits shifted into the divider
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned WRAP_W = 18;

  localparam logic [SHF_W-1:0]   RPM_NUM   = 26'd60000000;
  localparam logic [ANGLE_W-1:0] TURN_CDEG = 16'd36000;
  localparam logic [WRAP_W:0]    WRAP_BIAS = 19'd72000;   // two turns

  localparam logic [RPM_W-1:0]   RPM_MAX   = 16'hFFFF;

endpackage

`default_nettype wire

### hw/rtl/missing_tooth_crank_decoder.sv
// Missing-tooth crank wheel decoder: tooth period tracking, gap sync, rpm and angle.
// Depends on mtcd_pkg. Checked by mtcd_checker, bound in from its own file.
//
// One word is taken at a time; in_stall is high from acceptance until the result
// has been moved into the output register, which may still be waiting on out_stall
// when the next word is taken. A noise edge or a gap edge goes straight to the
// output stage. An edge that enters the average runs the 26 steps of the shared
// restoring divider that recomputes rpm. A query runs 6 divider steps to reduce
// the tooth offset, the S_DIST and S_MUL multiplies to form the numerator, 16 divider
// steps to give the angle and up to 4 steps to wrap it into 0..35999. A query that
// finds no valid angle goes straight to the output stage. The divider is the single
// shared unit; rpm is kept from the last edge that entered the average so a query does not repeat that division.
`default_nettype none

module missing_tooth_crank_decoder #(
  parameter int unsigned TEETH_TOTAL   = 60,
  parameter int unsigned TEETH_MISSING = 2
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [mtcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mtcd_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                operation,
  input  wire logic [mtcd_pkg::TIME_W-1:0]         time_us,
  // output channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [mtcd_pkg::RPM_W-1:0]               rpm,
  output logic                                     is_synced,
  output logic signed [mtcd_pkg::POS_W-1:0]        tooth_number,
  output logic [mtcd_pkg::ANGLE_W-1:0]             angle_cdeg,
  output logic                                     angle_valid,
  output logic                                     engine_running,
  output logic [mtcd_pkg::TIME_W-1:0]              average_period_us,
  output logic                                     gap_detected
);

  localparam logic [mtcd_pkg::TOOTH_W-1:0] TEETH = mtcd_pkg::TOOTH_W'(TEETH_TOTAL);
  localparam logic signed [mtcd_pkg::POS_W-1:0] POS_LAST =
    mtcd_pkg::POS_W'(TEETH_TOTAL - TEETH_MISSING);

  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] S_EDGE  = 4'd1;
  localparam logic [ST_W-1:0] S_DEN   = 4'd2;
  localparam logic [ST_W-1:0] S_QUERY = 4'd3;
  localparam logic [ST_W-1:0] S_DIV   = 4'd4;
  localparam logic [ST_W-1:0] S_POST  = 4'd5;
  localparam logic [ST_W-1:0] S_DIST  = 4'd6;
  localparam logic [ST_W-1:0] S_MUL   = 4'd7;
  localparam logic [ST_W-1:0] S_LOAD  = 4'd8;
  localparam logic [ST_W-1:0] S_WRAP  = 4'd9;
  localparam logic [ST_W-1:0] S_OUT   = 4'd10;

  // what the divider is working on
  localparam int unsigned PH_W = 2;
  localparam logic [PH_W-1:0] PH_RPM = 2'd0;
  localparam logic [PH_W-1:0] PH_OFF = 2'd1;
  localparam logic [PH_W-1:0] PH_ANG = 2'd2;

  // configuration registers
  logic [mtcd_pkg::TOOTH_W-1:0]       tooth_offset;
  logic signed [mtcd_pkg::FINE_W-1:0] fine_offset;
  logic [mtcd_pkg::NOISE_W-1:0]       noise_min;
  logic [mtcd_pkg::TMO_W-1:0]         stop_timeout;

  // decoder state
  logic [mtcd_pkg::TIME_W-1:0]        last_edge_time;
  logic [mtcd_pkg::TIME_W-1:0]        period_history [mtcd_pkg::HIST_DEPTH];
  logic [mtcd_pkg::HIST_PTR_W-1:0]    history_pointer;
  logic [mtcd_pkg::SUM_W-1:0]         history_sum;
  logic [mtcd_pkg::TIME_W-1:0]        mean_period;
  logic [mtcd_pkg::TIME_W-1:0]        last_good_period;
  logic signed [mtcd_pkg::POS_W-1:0]  tooth_position;
  logic                               sync_flag;
  logic [mtcd_pkg::RPM_W-1:0]         rpm_value;

  // per-word working registers
  logic [ST_W-1:0]                    state;
  logic [PH_W-1:0]                    phase;
  logic                               op_r;
  logic [mtcd_pkg::TIME_W-1:0]        now_r;
  logic                               gap_r;
  logic                               valid_r;
  logic [mtcd_pkg::ANGLE_W-1:0]       angle_r;
  logic [mtcd_pkg::DEN_W-1:0]         den;
  logic [mtcd_pkg::TIME_W-1:0]        frac_r;
  logic [mtcd_pkg::TOOTH_W-1:0]       offset_mod;
  logic [mtcd_pkg::DEN_W-1:0]         dist_r;
  logic [mtcd_pkg::NUM_W-1:0]         num_r;
  logic [mtcd_pkg::WRAP_W-1:0]        wrap_r;

  // shared divider
  logic [mtcd_pkg::DEN_W-1:0]         div_rem;
  logic [mtcd_pkg::SHF_W-1:0]         div_shf;
  logic [mtcd_pkg::SHF_W-1:0]         div_quo;
  logic [mtcd_pkg::CNT_W-1:0]         div_cnt;
  logic                               div_use_den;

  // combinational helpers
  logic [mtcd_pkg::TIME_W-1:0]        elapsed;
  logic [mtcd_pkg::SUM_W-1:0]         gap_sum3;
  logic                               gap_hit;
  logic [mtcd_pkg::SUM_W-1:0]         sum_next;
  logic signed [mtcd_pkg::POS_W-1:0]  pos_inc;
  logic [mtcd_pkg::DEN_W-1:0]         divisor;
  logic [mtcd_pkg::DEN_W+1:0]         trial;
  logic                               trial_ok;
  logic signed [mtcd_pkg::POS_W:0]    dist_diff;
  logic [mtcd_pkg::POS_W:0]           dist_fix;
  logic signed [mtcd_pkg::WRAP_W:0]   wrap_init;
  logic                               out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    elapsed  = now_r - last_edge_time;
    gap_sum3 = {2'b00, mean_period} + {1'b0, mean_period, 1'b0};
    gap_hit  = (mean_period != '0) && ({1'b0, elapsed} > gap_sum3[mtcd_pkg::SUM_W-1:1]);
    sum_next = history_sum - {2'b00, period_history[history_pointer]} + {2'b00, elapsed};
    pos_inc  = tooth_position + 7'sd1;

    divisor  = div_use_den ? den : mtcd_pkg::DEN_W'(TEETH);
    trial    = {1'b0, div_rem, div_shf[mtcd_pkg::SHF_W-1]} - {2'b00, divisor};
    trial_ok = !trial[mtcd_pkg::DEN_W+1];

    // teeth since top dead centre, modulo the tooth count
    dist_diff = $signed({1'b0, tooth_position}) - $signed({2'b00, offset_mod});
    dist_fix  = dist_diff[mtcd_pkg::POS_W] ?
                8'(dist_diff + $signed({2'b00, TEETH})) : 8'(dist_diff);

    wrap_init = $signed({3'b000, div_quo[mtcd_pkg::ANGLE_W-1:0]})
              - $signed({{2{fine_offset[mtcd_pkg::FINE_W-1]}}, fine_offset})
              + $signed(mtcd_pkg::WRAP_BIAS);
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tooth_offset <= '0;
      fine_offset  <= '0;
      noise_min    <= 16'd300;
      stop_timeout <= 24'd300000;
    end else if (cfg_we) begin
      case (cfg_index)
        mtcd_pkg::CFG_TOOTH_OFFSET: tooth_offset <= cfg_data[mtcd_pkg::TOOTH_W-1:0];
        mtcd_pkg::CFG_FINE_OFFSET:  fine_offset  <= $signed(cfg_data[mtcd_pkg::FINE_W-1:0]);
        mtcd_pkg::CFG_NOISE_MIN:    noise_min    <= cfg_data[mtcd_pkg::NOISE_W-1:0];
        mtcd_pkg::CFG_STOP_TIMEOUT: stop_timeout <= cfg_data[mtcd_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      phase            <= PH_RPM;
      out_valid        <= 1'b0;
      last_edge_time   <= '0;
      for (int i = 0; i < mtcd_pkg::HIST_DEPTH; i++) begin
        period_history[i] <= '0;
      end
      history_pointer  <= '0;
      history_sum      <= '0;
      mean_period      <= '0;
      last_good_period <= '0;
      tooth_position   <= '0;
      sync_flag        <= 1'b0;
      rpm_value        <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= operation;
            now_r   <= time_us;
            gap_r   <= 1'b0;
            valid_r <= 1'b0;
            angle_r <= '0;
            state   <= (operation == mtcd_pkg::OP_QUERY) ? S_QUERY : S_EDGE;
          end
        end
        S_EDGE: begin
          last_edge_time <= now_r;
          if (elapsed < {16'd0, noise_min}) begin
            state <= S_OUT;
          end else if (gap_hit) begin
            gap_r          <= 1'b1;
            tooth_position <= '0;
            sync_flag      <= 1'b1;
            state          <= S_OUT;
          end else begin
            period_history[history_pointer] <= elapsed;
            history_pointer  <= history_pointer + 2'd1;
            history_sum      <= sum_next;
            mean_period      <= sum_next[mtcd_pkg::SUM_W-1:mtcd_pkg::HIST_PTR_W];
            last_good_period <= elapsed;
            if (sync_flag) begin
              if (pos_inc >= POS_LAST) begin
                sync_flag      <= 1'b0;
                tooth_position <= -7'sd1;
              end else begin
                tooth_position <= pos_inc;
              end
            end
            state <= S_DEN;
          end
        end
        S_DEN: begin
          // new period: refresh rpm through the divider
          den         <= mtcd_pkg::DEN_W'(last_good_period) * mtcd_pkg::DEN_W'(TEETH);
          div_rem     <= '0;
          div_shf     <= mtcd_pkg::RPM_NUM;
          div_quo     <= '0;
          div_cnt     <= mtcd_pkg::CNT_W'(mtcd_pkg::SHF_W);
          div_use_den <= 1'b1;
          phase       <= PH_RPM;
          state       <= S_DIV;
        end
        S_QUERY: begin
          if (!sync_flag || tooth_position[mtcd_pkg::POS_W-1] || last_good_period == '0) begin
            state <= S_OUT;
          end else begin
            den         <= mtcd_pkg::DEN_W'(last_good_period) * mtcd_pkg::DEN_W'(TEETH);
            frac_r      <= (elapsed > last_good_period) ? last_good_period : elapsed;
            // offset modulo the tooth count
            div_rem     <= '0;
            div_shf     <= {tooth_offset, {(mtcd_pkg::SHF_W-mtcd_pkg::TOOTH_W){1'b0}}};
            div_quo     <= '0;
            div_cnt     <= mtcd_pkg::CNT_W'(mtcd_pkg::TOOTH_W);
            div_use_den <= 1'b0;
            phase       <= PH_OFF;
            state       <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem <= trial_ok ? trial[mtcd_pkg::DEN_W-1:0]
                              : {div_rem[mtcd_pkg::DEN_W-2:0], div_shf[mtcd_pkg::SHF_W-1]};
          div_shf <= {div_shf[mtcd_pkg::SHF_W-2:0], 1'b0};
          div_quo <= {div_quo[mtcd_pkg::SHF_W-2:0], trial_ok};
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == 5'd1) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          case (phase)
            PH_RPM: begin
              if (last_good_period == '0) begin
                rpm_value <= '0;
              end else if (div_quo[mtcd_pkg::SHF_W-1:mtcd_pkg::RPM_W] != '0) begin
                rpm_value <= mtcd_pkg::RPM_MAX;
              end else begin
                rpm_value <= div_quo[mtcd_pkg::RPM_W-1:0];
              end
              state <= S_OUT;
            end
            PH_OFF: begin
              offset_mod <= div_rem[mtcd_pkg::TOOTH_W-1:0];
              state      <= S_DIST;
            end
            PH_ANG: begin
              wrap_r <= wrap_init[mtcd_pkg::WRAP_W-1:0];
              state  <= S_WRAP;
            end
            default: state <= S_OUT;
          endcase
        end
        S_DIST: begin
          dist_r <= mtcd_pkg::DEN_W'(dist_fix[mtcd_pkg::TOOTH_W-1:0])
                  * mtcd_pkg::DEN_W'(last_good_period) + {6'd0, frac_r};
          state  <= S_MUL;
        end
        S_MUL: begin
          num_r <= mtcd_pkg::NUM_W'(dist_r) * mtcd_pkg::NUM_W'(mtcd_pkg::TURN_CDEG);
          state <= S_LOAD;
        end
        S_LOAD: begin
          // quotient stays below 2^16, so the top bits start as remainder
          div_rem     <= num_r[mtcd_pkg::NUM_W-1:mtcd_pkg::ANGLE_W];
          div_shf     <= {num_r[mtcd_pkg::ANGLE_W-1:0],
                          {(mtcd_pkg::SHF_W-mtcd_pkg::ANGLE_W){1'b0}}};
          div_quo     <= '0;
          div_cnt     <= mtcd_pkg::CNT_W'(mtcd_pkg::ANGLE_W);
          div_use_den <= 1'b1;
          phase       <= PH_ANG;
          state       <= S_DIV;
        end
        S_WRAP: begin
          if (wrap_r >= {2'b00, mtcd_pkg::TURN_CDEG}) begin
            wrap_r <= wrap_r - {2'b00, mtcd_pkg::TURN_CDEG};
          end else begin
            angle_r <= wrap_r[mtcd_pkg::ANGLE_W-1:0];
            valid_r <= 1'b1;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            rpm               <= rpm_value;
            is_synced         <= sync_flag;
            tooth_number      <= tooth_position;
            angle_cdeg        <= angle_r;
            angle_valid       <= valid_r && (op_r == mtcd_pkg::OP_QUERY);
            engine_running    <= (elapsed < {8'd0, stop_timeout});
            average_period_us <= mean_period;
            gap_detected      <= gap_r;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/mtcd_checker.sv
// Port-level checks of the missing-tooth crank decoder output words.
// Depends on mtcd_pkg; bound to missing_tooth_crank_decoder at the end of this file.
`default_nettype none

module mtcd_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [mtcd_pkg::RPM_W-1:0]         rpm,
  input wire logic                               is_synced,
  input wire logic signed [mtcd_pkg::POS_W-1:0]  tooth_number,
  input wire logic [mtcd_pkg::ANGLE_W-1:0]       angle_cdeg,
  input wire logic                               angle_valid,
  input wire logic                               gap_detected
);

  // a waiting word keeps its speed value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rpm))
    else $error("stalled output word changed");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && angle_valid |-> angle_cdeg < mtcd_pkg::TURN_CDEG && is_synced)
    else $error("valid angle out of range or without sync");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !angle_valid |-> angle_cdeg == '0)
    else $error("invalid angle not zero");

  // the gap restarts counting at tooth zero with sync
  assert property (@(posedge clk) disable iff (rst)
    out_valid && gap_detected |-> is_synced && tooth_number == '0 && !angle_valid)
    else $error("gap word without sync at tooth zero");

endmodule

bind missing_tooth_crank_decoder mtcd_checker u_mtcd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .rpm          (rpm),
  .is_synced    (is_synced),
  .tooth_number (tooth_number),
  .angle_cdeg   (angle_cdeg),
  .angle_valid  (angle_valid),
  .gap_detected (gap_detected)
);

`default_nettype wire
